>>> design/imf_pkg.sv
// Package for the ISAP max-flow block: default sizes, field widths and
// configuration register indexes. No dependencies.
package imf_pkg;

	localparam int MAX_NODES_DEF = 64;
	localparam int CAP_BITS_DEF = 16;

	// Result and configuration field widths
	localparam int FLOW_W = 22;
	localparam int NCNT_W = 7;
	localparam int NODE_CFG_W = 6;
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	// Configuration register indexes (paddr[3:2])
	localparam logic [1:0] REG_NODE_COUNT = 2'd0;
	localparam logic [1:0] REG_SOURCE = 2'd1;
	localparam logic [1:0] REG_SINK = 2'd2;

	// Input item opcodes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_RUN = 1'b1;

endpackage

>>> design/isap_max_flow_matrix_top.sv
// ISAP max-flow engine on a dense capacity matrix, with its APB register port.
// Depends on imf_pkg.

// A capacity write (opcode 0) keeps busy low, so writes can follow each other
// in every cycle. A run (opcode 1) raises busy. Unless the configuration gives
// no flow, it starts with a clearing sweep over the flow matrix. Each node the
// walk stands on then has its label and current arc loaded. Each arc the walk
// examines takes a memory read and then an evaluate step. A relabel reads the
// arcs to all n nodes in use. Each path arc passes through ST_BN to ST_BN3 while
// the bottleneck is found and ST_AG to ST_AG4 while it is pushed. The single
// read port of each matrix memory is why these steps run one after another.
// After reset the block clears the capacity matrix before it takes its first
// item; APB writes are taken meanwhile. The result comes with done high for one
// cycle and cannot be held off, so the receiver must take it then.
module isap_max_flow_matrix_top
	import imf_pkg::*;
#(
	parameter int MAX_NODES = MAX_NODES_DEF,
	parameter int CAP_BITS = CAP_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic opcode,
	input logic [$clog2(MAX_NODES)-1:0] row,
	input logic [$clog2(MAX_NODES)-1:0] col,
	input logic [CAP_BITS-1:0] capacity,
	output logic done,
	output logic [FLOW_W-1:0] max_flow,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [APB_AW-1:0] paddr,
	input logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic pready
);

	localparam int NB = $clog2(MAX_NODES);
	localparam int DB = $clog2(MAX_NODES + 1);
	localparam int AB = $clog2(MAX_NODES * MAX_NODES);
	localparam int FW = CAP_BITS + 1;
	localparam int RW = CAP_BITS + 2;
	localparam int CW = DB + NCNT_W + 1;
	localparam int DEPTH = MAX_NODES * MAX_NODES;

	typedef enum logic [19:0] {
		ST_IDLE   = 20'h00001,
		ST_CLR    = 20'h00002,
		ST_SETUP  = 20'h00004,
		ST_TOP    = 20'h00008,
		ST_LDU    = 20'h00010,
		ST_SCAN   = 20'h00020,
		ST_SCAN2  = 20'h00040,
		ST_RLB    = 20'h00080,
		ST_RLB2   = 20'h00100,
		ST_GAPRD  = 20'h00200,
		ST_GAPCHK = 20'h00400,
		ST_GAPINC = 20'h00800,
		ST_BN     = 20'h01000,
		ST_BN2    = 20'h02000,
		ST_BN3    = 20'h04000,
		ST_AG     = 20'h08000,
		ST_AG2    = 20'h10000,
		ST_AG3    = 20'h20000,
		ST_AG4    = 20'h40000,
		ST_DONE   = 20'h80000
	} state_t;

	function automatic logic [AB-1:0] mat_addr(input logic [NB-1:0] r, input logic [NB-1:0] c);
		return AB'(r) * AB'(MAX_NODES) + AB'(c);
	endfunction

	state_t state_q;

	// Configuration registers
	logic [NCNT_W-1:0] node_count_q;
	logic [NODE_CFG_W-1:0] source_q;
	logic [NODE_CFG_W-1:0] sink_q;

	// Run control registers
	logic wipe_q;
	logic [AB-1:0] cnt_q;
	logic [DB-1:0] n_q;
	logic [NB-1:0] s_q;
	logic [NB-1:0] t_q;
	logic [NB-1:0] u_q;
	logic [DB-1:0] v_q;
	logic [DB-1:0] du_q;
	logic [DB-1:0] mind_q;
	logic [DB-1:0] dist_s_q;
	logic [DB-1:0] g_q;
	logic same_q;
	logic [NB-1:0] bv_q;
	logic [NB-1:0] p_q;
	logic [DB-1:0] steps_q;
	logic signed [RW-1:0] bneck_q;
	logic bset_q;
	logic [FLOW_W-1:0] total_q;
	logic done_q;
	logic [FLOW_W-1:0] max_flow_q;

	// Memories and their ports
	logic [CAP_BITS-1:0] cap_mem [DEPTH];
	logic signed [FW-1:0] flw_mem [DEPTH];
	logic [DB-1:0] dst_mem [MAX_NODES];
	logic [NB-1:0] cur_mem [MAX_NODES];
	logic [NB-1:0] prd_mem [MAX_NODES];
	logic [DB-1:0] gap_mem [MAX_NODES + 1];

	logic cap_we;
	logic [AB-1:0] cap_wa, cap_ra;
	logic [CAP_BITS-1:0] cap_wd, cap_rd_q;
	logic flw_we;
	logic [AB-1:0] flw_wa, flw_ra;
	logic signed [FW-1:0] flw_wd, flw_rd_q;
	logic dst_we;
	logic [NB-1:0] dst_wa, dst_ra;
	logic [DB-1:0] dst_wd, dst_rd_q;
	logic cur_we;
	logic [NB-1:0] cur_wa, cur_ra;
	logic [NB-1:0] cur_wd, cur_rd_q;
	logic prd_we;
	logic [NB-1:0] prd_wa, prd_ra;
	logic [NB-1:0] prd_wd, prd_rd_q;
	logic gap_we;
	logic [DB-1:0] gap_wa, gap_ra;
	logic [DB-1:0] gap_wd, gap_rd_q;

	// Derived values
	logic cfg_wr;
	logic accept;
	logic [CW-1:0] nc_w, n_w;
	logic degenerate;
	logic signed [RW-1:0] res_w;
	logic [DB:0] dv_inc;
	logic admissible;
	logic [DB-1:0] g_dec;
	logic [DB-1:0] mind_inc;
	logic clr_last;
	logic row_ok;

	assign cfg_wr = psel & penable & pwrite;
	assign accept = start & ~busy;
	assign busy = (state_q != ST_IDLE);
	assign pready = 1'b1;
	assign done = done_q;
	assign max_flow = max_flow_q;

	// Register readback
	always_comb begin
		unique case (paddr[3:2])
			REG_NODE_COUNT: prdata = APB_DW'(node_count_q);
			REG_SOURCE: prdata = APB_DW'(source_q);
			REG_SINK: prdata = APB_DW'(sink_q);
			default: prdata = '0;
		endcase
	end

	// Effective node count and the cases that give no flow
	assign nc_w = CW'(node_count_q);
	assign n_w = (nc_w > CW'(MAX_NODES)) ? CW'(MAX_NODES) : nc_w;
	assign degenerate = (n_w < CW'(2)) || (CW'(source_q) >= n_w) || (CW'(sink_q) >= n_w)
		|| (source_q == sink_q);

	assign res_w = $signed(RW'(cap_rd_q)) - RW'(flw_rd_q);
	assign dv_inc = (DB + 1)'(dst_rd_q) + (DB + 1)'(1);
	assign admissible = (res_w != '0) && ((DB + 1)'(du_q) == dv_inc);
	assign g_dec = gap_rd_q - DB'(1);
	assign mind_inc = mind_q + DB'(1);
	assign clr_last = (cnt_q == AB'(DEPTH - 1));
	assign row_ok = (32'(row) < MAX_NODES) && (32'(col) < MAX_NODES);

	// Steer memory ports from the sequencer
	always_comb begin
		cap_we = 1'b0;
		cap_wa = cnt_q;
		cap_wd = '0;
		cap_ra = mat_addr(u_q, v_q[NB-1:0]);
		flw_we = 1'b0;
		flw_wa = cnt_q;
		flw_wd = '0;
		flw_ra = mat_addr(u_q, v_q[NB-1:0]);
		dst_we = 1'b0;
		dst_wa = cnt_q[NB-1:0];
		dst_wd = '0;
		dst_ra = v_q[NB-1:0];
		cur_we = 1'b0;
		cur_wa = cnt_q[NB-1:0];
		cur_wd = '0;
		cur_ra = u_q;
		prd_we = 1'b0;
		prd_wa = s_q;
		prd_wd = s_q;
		prd_ra = bv_q;
		gap_we = 1'b0;
		gap_wa = DB'(cnt_q);
		gap_wd = '0;
		gap_ra = du_q;
		unique case (state_q)
			ST_IDLE: begin
				cap_we = accept && (opcode == OP_WRITE) && row_ok;
				cap_wa = mat_addr(row, col);
				cap_wd = capacity;
			end
			ST_CLR: begin
				cap_we = wipe_q;
				flw_we = 1'b1;
				dst_we = (32'(cnt_q) < MAX_NODES);
				cur_we = (32'(cnt_q) < MAX_NODES);
				gap_we = (32'(cnt_q) < MAX_NODES + 1);
			end
			ST_SETUP: begin
				prd_we = 1'b1;
				gap_we = 1'b1;
				gap_wa = '0;
				gap_wd = n_q;
			end
			ST_TOP: begin
				dst_ra = u_q;
			end
			ST_SCAN2: begin
				prd_we = admissible;
				prd_wa = v_q[NB-1:0];
				prd_wd = u_q;
				cur_we = admissible;
				cur_wa = u_q;
				cur_wd = v_q[NB-1:0];
			end
			ST_RLB2: begin
				cur_we = (res_w != '0) && (mind_q > dst_rd_q);
				cur_wa = u_q;
				cur_wd = v_q[NB-1:0];
			end
			ST_GAPCHK: begin
				gap_we = (g_dec != '0);
				gap_wa = du_q;
				gap_wd = g_dec;
				gap_ra = mind_inc;
				dst_we = (g_dec != '0);
				dst_wa = u_q;
				dst_wd = mind_inc;
				prd_ra = u_q;
			end
			ST_GAPINC: begin
				gap_we = 1'b1;
				gap_wa = mind_inc;
				gap_wd = (same_q ? g_q : gap_rd_q) + DB'(1);
			end
			ST_BN2: begin
				cap_ra = mat_addr(prd_rd_q, bv_q);
				flw_ra = mat_addr(prd_rd_q, bv_q);
			end
			ST_AG2: begin
				flw_ra = mat_addr(prd_rd_q, bv_q);
			end
			ST_AG3: begin
				flw_we = 1'b1;
				flw_wa = mat_addr(p_q, bv_q);
				flw_wd = FW'(RW'(flw_rd_q) + bneck_q);
				flw_ra = mat_addr(bv_q, p_q);
			end
			ST_AG4: begin
				flw_we = 1'b1;
				flw_wa = mat_addr(bv_q, p_q);
				flw_wd = FW'(RW'(flw_rd_q) - bneck_q);
			end
			default: begin
			end
		endcase
	end

	// Matrix memories: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cap_we) begin
			cap_mem[cap_wa] <= cap_wd;
		end
		cap_rd_q <= cap_mem[cap_ra];
		if (flw_we) begin
			flw_mem[flw_wa] <= flw_wd;
		end
		flw_rd_q <= flw_mem[flw_ra];
	end

	// Per-node memories
	always_ff @(posedge clk) begin
		if (dst_we) begin
			dst_mem[dst_wa] <= dst_wd;
		end
		dst_rd_q <= dst_mem[dst_ra];
		if (cur_we) begin
			cur_mem[cur_wa] <= cur_wd;
		end
		cur_rd_q <= cur_mem[cur_ra];
		if (prd_we) begin
			prd_mem[prd_wa] <= prd_wd;
		end
		prd_rd_q <= prd_mem[prd_ra];
		if (gap_we) begin
			gap_mem[gap_wa] <= gap_wd;
		end
		gap_rd_q <= gap_mem[gap_ra];
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NCNT_W'(2);
			source_q <= '0;
			sink_q <= NODE_CFG_W'(1);
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_NODE_COUNT: node_count_q <= pwdata[NCNT_W-1:0];
				REG_SOURCE: source_q <= pwdata[NODE_CFG_W-1:0];
				REG_SINK: sink_q <= pwdata[NODE_CFG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			wipe_q <= 1'b1;
			cnt_q <= '0;
			done_q <= 1'b0;
			max_flow_q <= '0;
			total_q <= '0;
			n_q <= '0;
			s_q <= '0;
			t_q <= '0;
			u_q <= '0;
			v_q <= '0;
			du_q <= '0;
			mind_q <= '0;
			dist_s_q <= '0;
			g_q <= '0;
			same_q <= 1'b0;
			bv_q <= '0;
			p_q <= '0;
			steps_q <= '0;
			bneck_q <= '0;
			bset_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (opcode == OP_RUN)) begin
						total_q <= '0;
						n_q <= DB'(n_w);
						s_q <= NB'(source_q);
						t_q <= NB'(sink_q);
						cnt_q <= '0;
						state_q <= degenerate ? ST_DONE : ST_CLR;
					end
				end
				// Sweep the flow matrix and per-node stores, and the capacity matrix after reset
				ST_CLR: begin
					cnt_q <= cnt_q + AB'(1);
					if (clr_last) begin
						wipe_q <= 1'b0;
						state_q <= wipe_q ? ST_IDLE : ST_SETUP;
					end
				end
				ST_SETUP: begin
					u_q <= s_q;
					dist_s_q <= '0;
					state_q <= ST_TOP;
				end
				ST_TOP: begin
					state_q <= (dist_s_q >= n_q) ? ST_DONE : ST_LDU;
				end
				ST_LDU: begin
					du_q <= dst_rd_q;
					v_q <= DB'(cur_rd_q);
					state_q <= ST_SCAN;
				end
				// Look for an admissible arc from the current arc onward
				ST_SCAN: begin
					if (v_q >= n_q) begin
						v_q <= '0;
						mind_q <= n_q - DB'(1);
						state_q <= ST_RLB;
					end else begin
						state_q <= ST_SCAN2;
					end
				end
				ST_SCAN2: begin
					if (admissible) begin
						u_q <= v_q[NB-1:0];
						if (v_q[NB-1:0] == t_q) begin
							bv_q <= t_q;
							steps_q <= '0;
							bset_q <= 1'b0;
							state_q <= ST_BN;
						end else begin
							state_q <= ST_TOP;
						end
					end else begin
						v_q <= v_q + DB'(1);
						state_q <= ST_SCAN;
					end
				end
				// Relabel: find the lowest label among neighbors with residual capacity
				ST_RLB: begin
					state_q <= (v_q >= n_q) ? ST_GAPRD : ST_RLB2;
				end
				ST_RLB2: begin
					if ((res_w != '0) && (mind_q > dst_rd_q)) begin
						mind_q <= dst_rd_q;
					end
					v_q <= v_q + DB'(1);
					state_q <= ST_RLB;
				end
				ST_GAPRD: begin
					state_q <= ST_GAPCHK;
				end
				// Stop on an empty gap, else move the label and retreat
				ST_GAPCHK: begin
					if (g_dec == '0) begin
						state_q <= ST_DONE;
					end else begin
						g_q <= g_dec;
						same_q <= (mind_inc == du_q);
						if (u_q == s_q) begin
							dist_s_q <= mind_inc;
						end
						state_q <= ST_GAPINC;
					end
				end
				ST_GAPINC: begin
					u_q <= prd_rd_q;
					state_q <= ST_TOP;
				end
				// Walk back from the sink for the bottleneck
				ST_BN: begin
					if ((bv_q == s_q) || (steps_q >= n_q)) begin
						if (!bset_q || bneck_q[RW-1]) begin
							bneck_q <= '0;
						end
						bv_q <= t_q;
						steps_q <= '0;
						state_q <= ST_AG;
					end else begin
						state_q <= ST_BN2;
					end
				end
				ST_BN2: begin
					p_q <= prd_rd_q;
					state_q <= ST_BN3;
				end
				ST_BN3: begin
					if (!bset_q || (res_w < bneck_q)) begin
						bneck_q <= res_w;
					end
					bset_q <= 1'b1;
					bv_q <= p_q;
					steps_q <= steps_q + DB'(1);
					state_q <= ST_BN;
				end
				// Push the bottleneck along the path
				ST_AG: begin
					if ((bv_q == s_q) || (steps_q >= n_q)) begin
						total_q <= total_q + FLOW_W'($unsigned(bneck_q));
						u_q <= s_q;
						state_q <= ST_TOP;
					end else begin
						state_q <= ST_AG2;
					end
				end
				ST_AG2: begin
					p_q <= prd_rd_q;
					state_q <= ST_AG3;
				end
				ST_AG3: begin
					state_q <= ST_AG4;
				end
				ST_AG4: begin
					bv_q <= p_q;
					steps_q <= steps_q + DB'(1);
					state_q <= ST_AG;
				end
				ST_DONE: begin
					done_q <= 1'b1;
					max_flow_q <= total_q;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The result strobe lasts one cycle
	assert property (@(posedge clk) disable iff (!arst_n) done_q |=> !done_q)
		else $error("done held longer than one cycle");

	// A result follows only the final state of a run
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> $past(state_q == ST_DONE))
		else $error("done raised outside the end of a run");

	// A raised label stays within the gap table
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GAPINC) |-> (mind_q < n_q))
		else $error("relabel target beyond node count");

	// The pushed bottleneck is never negative
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_AG3) |-> !bneck_q[RW-1])
		else $error("negative bottleneck pushed");

endmodule
